// ===== rtl/cpc_pkg.sv =====
// Shared types and constants for the correlation phase corrector.
package cpc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CORR_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int ACC_W = 48;
  localparam int ACC_EXT_W = ACC_W + 1;
  localparam int MUL_W = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W = PROD_W + 1;
  localparam int NORM_W = 30;
  localparam int SQ_W = 2 * NORM_W + 2;
  localparam int MAG_W = NORM_W + 1;
  localparam int Q_BITS = 15;
  localparam int FRAC_W = 14;
  localparam int DIV_W = MAG_W + FRAC_W;
  localparam int DCNT_W = 4;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam int COR_ROUND = 8192;
  localparam int COR_SHIFT = 14;
  localparam int SMOOTH_ROUND = 32768;
  localparam int SMOOTH_SHIFT = 16;

  localparam logic signed [CORR_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd32768;
  localparam logic [WEIGHT_W:0] WEIGHT_ONE = 17'h10000;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
  localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << (2 * NORM_W);

  localparam logic ACT_ACC = 1'b0;
  localparam logic ACT_COR = 1'b1;

  typedef enum logic [1:0] {
    OP_ACC     = 2'd0,
    OP_ACC_END = 2'd1,
    OP_COR     = 2'd2
  } op_t;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic signed [SAMPLE_W-1:0] ref_re;
    logic signed [SAMPLE_W-1:0] ref_im;
    logic                       block_end;
  } in_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic signed [SAMPLE_W-1:0] ref_re;
    logic signed [SAMPLE_W-1:0] ref_im;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;
    logic signed [CORR_W-1:0]   corr_re;
    logic signed [CORR_W-1:0]   corr_im;
    logic                       corr_updated;
  } out_t;

endpackage

// ===== rtl/cpc_front.sv =====
// Input stage that accepts items and classifies them into operations.
module cpc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpc_pkg::in_t   in_data,
  output logic           push,
  output cpc_pkg::item_t push_item,
  input  logic           full
);

  logic           f_valid;
  cpc_pkg::item_t f_item;
  cpc_pkg::item_t f_item_next;
  logic           take;

  assign in_ready = !f_valid || !full;
  assign take = in_valid && in_ready;
  assign push = f_valid && !full;
  assign push_item = f_item;

  always_comb begin
    f_item_next.sample_re = in_data.sample_re;
    f_item_next.sample_im = in_data.sample_im;
    f_item_next.ref_re = in_data.ref_re;
    f_item_next.ref_im = in_data.ref_im;
    if (in_data.action == cpc_pkg::ACT_COR) begin
      f_item_next.op = cpc_pkg::OP_COR;
    end else if (in_data.block_end) begin
      f_item_next.op = cpc_pkg::OP_ACC_END;
    end else begin
      f_item_next.op = cpc_pkg::OP_ACC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_item <= f_item_next;
    end
  end

endmodule

// ===== rtl/cpc_queue.sv =====
// Short queue of classified items between the front and back ends.
module cpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output cpc_pkg::item_t pop_item,
  output logic           empty
);

  cpc_pkg::item_t                mem [cpc_pkg::QDEPTH];
  logic [cpc_pkg::QPTR_W-1:0]    wptr;
  logic [cpc_pkg::QPTR_W-1:0]    rptr;
  logic [cpc_pkg::QPTR_W:0]      count;

  assign full = count == (cpc_pkg::QPTR_W + 1)'(cpc_pkg::QDEPTH);
  assign empty = count == '0;
  assign pop_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + cpc_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + cpc_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (cpc_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (cpc_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

// ===== rtl/cpc_back.sv =====
// Execution engine: correlation, normalization, smoothing and correction.
module cpc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cpc_pkg::WEIGHT_W-1:0]      weight,
  output logic                              pop,
  input  cpc_pkg::item_t                    pop_item,
  input  logic                              empty,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cpc_pkg::out_t                     out_data
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_MUL   = 14'h0002,
    S_SUM   = 14'h0004,
    S_ACC   = 14'h0008,
    S_COR   = 14'h0010,
    S_NINIT = 14'h0020,
    S_NORM  = 14'h0040,
    S_SQ    = 14'h0080,
    S_SQI   = 14'h0100,
    S_SQRT  = 14'h0200,
    S_DINIT = 14'h0400,
    S_DIV   = 14'h0800,
    S_SADD  = 14'h1000,
    S_EMIT  = 14'h2000
  } state_t;

  state_t                                 state;
  cpc_pkg::item_t                         item;
  logic                                   smoothing;
  logic                                   div_sel;
  logic signed [cpc_pkg::ACC_W-1:0]       acc_re;
  logic signed [cpc_pkg::ACC_W-1:0]       acc_im;
  logic signed [cpc_pkg::CORR_W-1:0]      phase_re;
  logic signed [cpc_pkg::CORR_W-1:0]      phase_im;
  logic signed [cpc_pkg::PROD_W-1:0]      prod [4];
  logic signed [cpc_pkg::SUM_W-1:0]       s_re;
  logic signed [cpc_pkg::SUM_W-1:0]       s_im;
  logic [cpc_pkg::ACC_W-1:0]              mag_a;
  logic [cpc_pkg::ACC_W-1:0]              mag_b;
  logic                                   neg_re;
  logic                                   pos_im;
  logic [2*cpc_pkg::NORM_W-1:0]           sq_a;
  logic [2*cpc_pkg::NORM_W-1:0]           sq_b;
  logic [cpc_pkg::SQ_W-1:0]               sq_n;
  logic [cpc_pkg::SQ_W-1:0]               sq_r;
  logic [cpc_pkg::SQ_W-1:0]               sq_bit;
  logic [cpc_pkg::MAG_W-1:0]              mag;
  logic [cpc_pkg::DIV_W-1:0]              rem;
  logic [cpc_pkg::DIV_W-1:0]              den;
  logic [cpc_pkg::Q_BITS-1:0]             quo;
  logic [cpc_pkg::DCNT_W-1:0]             dcnt;
  logic signed [cpc_pkg::CORR_W-1:0]      est_re;
  logic signed [cpc_pkg::CORR_W-1:0]      est_im;
  logic signed [cpc_pkg::SAMPLE_W-1:0]    res_re;
  logic signed [cpc_pkg::SAMPLE_W-1:0]    res_im;
  logic                                   res_upd;

  logic signed [cpc_pkg::MUL_W-1:0]       mul_a [4];
  logic signed [cpc_pkg::MUL_W-1:0]       mul_b [4];
  logic signed [cpc_pkg::PROD_W-1:0]      prod_next [4];
  logic                                   sub_re;
  logic                                   sub_im;
  logic signed [cpc_pkg::SUM_W-1:0]       s_re_next;
  logic signed [cpc_pkg::SUM_W-1:0]       s_im_next;
  logic signed [cpc_pkg::ACC_EXT_W-1:0]   acc_sum_re;
  logic signed [cpc_pkg::ACC_EXT_W-1:0]   acc_sum_im;
  logic signed [cpc_pkg::ACC_W-1:0]       acc_re_next;
  logic signed [cpc_pkg::ACC_W-1:0]       acc_im_next;
  logic signed [cpc_pkg::SUM_W-1:0]       cor_re_sh;
  logic signed [cpc_pkg::SUM_W-1:0]       cor_im_sh;
  logic signed [cpc_pkg::SUM_W-1:0]       smo_re_sh;
  logic signed [cpc_pkg::SUM_W-1:0]       smo_im_sh;
  logic [cpc_pkg::ACC_W-1:0]              mag_max;
  logic [cpc_pkg::SQ_W-1:0]               sq_rb;
  logic                                   sq_ge;
  logic [cpc_pkg::SQ_W-1:0]               sq_r_next;
  logic [cpc_pkg::NORM_W-1:0]             div_x;
  logic                                   div_ge;
  logic [cpc_pkg::Q_BITS-1:0]             quo_next;
  logic signed [cpc_pkg::CORR_W-1:0]      quo_s;
  logic                                   slot_free;
  logic                                   div_last;

  function automatic logic signed [cpc_pkg::SAMPLE_W-1:0] sat_sample(
    input logic signed [cpc_pkg::SUM_W-1:0] v
  );
    logic [cpc_pkg::SUM_W-cpc_pkg::SAMPLE_W:0] hi;
    hi = v[cpc_pkg::SUM_W-1:cpc_pkg::SAMPLE_W-1];
    if ((&hi) || !(|hi)) begin
      return v[cpc_pkg::SAMPLE_W-1:0];
    end else if (v[cpc_pkg::SUM_W-1]) begin
      return {1'b1, {(cpc_pkg::SAMPLE_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(cpc_pkg::SAMPLE_W - 1){1'b1}}};
    end
  endfunction

  function automatic logic signed [cpc_pkg::CORR_W-1:0] sat_corr(
    input logic signed [cpc_pkg::SUM_W-1:0] v
  );
    logic [cpc_pkg::SUM_W-cpc_pkg::CORR_W:0] hi;
    hi = v[cpc_pkg::SUM_W-1:cpc_pkg::CORR_W-1];
    if ((&hi) || !(|hi)) begin
      return v[cpc_pkg::CORR_W-1:0];
    end else if (v[cpc_pkg::SUM_W-1]) begin
      return {1'b1, {(cpc_pkg::CORR_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(cpc_pkg::CORR_W - 1){1'b1}}};
    end
  endfunction

  assign pop = (state == S_IDLE) && !empty;
  assign slot_free = !out_valid || out_ready;
  assign div_last = dcnt == cpc_pkg::DCNT_W'(cpc_pkg::Q_BITS - 1);

  always_comb begin
    if (smoothing) begin
      mul_a[0] = signed'({2'b00, weight});
      mul_b[0] = cpc_pkg::MUL_W'(est_re);
      mul_a[1] = signed'({1'b0, cpc_pkg::WEIGHT_ONE - {1'b0, weight}});
      mul_b[1] = cpc_pkg::MUL_W'(phase_re);
      mul_a[2] = signed'({2'b00, weight});
      mul_b[2] = cpc_pkg::MUL_W'(est_im);
      mul_a[3] = signed'({1'b0, cpc_pkg::WEIGHT_ONE - {1'b0, weight}});
      mul_b[3] = cpc_pkg::MUL_W'(phase_im);
    end else if (item.op == cpc_pkg::OP_COR) begin
      mul_a[0] = cpc_pkg::MUL_W'(item.sample_re);
      mul_b[0] = cpc_pkg::MUL_W'(phase_re);
      mul_a[1] = cpc_pkg::MUL_W'(item.sample_im);
      mul_b[1] = cpc_pkg::MUL_W'(phase_im);
      mul_a[2] = cpc_pkg::MUL_W'(item.sample_re);
      mul_b[2] = cpc_pkg::MUL_W'(phase_im);
      mul_a[3] = cpc_pkg::MUL_W'(item.sample_im);
      mul_b[3] = cpc_pkg::MUL_W'(phase_re);
    end else begin
      mul_a[0] = cpc_pkg::MUL_W'(item.sample_re);
      mul_b[0] = cpc_pkg::MUL_W'(item.ref_re);
      mul_a[1] = cpc_pkg::MUL_W'(item.sample_im);
      mul_b[1] = cpc_pkg::MUL_W'(item.ref_im);
      mul_a[2] = cpc_pkg::MUL_W'(item.sample_im);
      mul_b[2] = cpc_pkg::MUL_W'(item.ref_re);
      mul_a[3] = cpc_pkg::MUL_W'(item.sample_re);
      mul_b[3] = cpc_pkg::MUL_W'(item.ref_im);
    end
    for (int i = 0; i < 4; i++) begin
      prod_next[i] = mul_a[i] * mul_b[i];
    end
    sub_re = !smoothing && (item.op == cpc_pkg::OP_COR);
    sub_im = !smoothing && (item.op != cpc_pkg::OP_COR);
    s_re_next = sub_re ? cpc_pkg::SUM_W'(prod[0]) - cpc_pkg::SUM_W'(prod[1])
                       : cpc_pkg::SUM_W'(prod[0]) + cpc_pkg::SUM_W'(prod[1]);
    s_im_next = sub_im ? cpc_pkg::SUM_W'(prod[2]) - cpc_pkg::SUM_W'(prod[3])
                       : cpc_pkg::SUM_W'(prod[2]) + cpc_pkg::SUM_W'(prod[3]);
  end

  always_comb begin
    acc_sum_re = cpc_pkg::ACC_EXT_W'(acc_re) + cpc_pkg::ACC_EXT_W'(s_re);
    acc_sum_im = cpc_pkg::ACC_EXT_W'(acc_im) + cpc_pkg::ACC_EXT_W'(s_im);
    if (acc_sum_re[cpc_pkg::ACC_W] != acc_sum_re[cpc_pkg::ACC_W-1]) begin
      acc_re_next = acc_sum_re[cpc_pkg::ACC_W] ? cpc_pkg::ACC_MIN : cpc_pkg::ACC_MAX;
    end else begin
      acc_re_next = acc_sum_re[cpc_pkg::ACC_W-1:0];
    end
    if (acc_sum_im[cpc_pkg::ACC_W] != acc_sum_im[cpc_pkg::ACC_W-1]) begin
      acc_im_next = acc_sum_im[cpc_pkg::ACC_W] ? cpc_pkg::ACC_MIN : cpc_pkg::ACC_MAX;
    end else begin
      acc_im_next = acc_sum_im[cpc_pkg::ACC_W-1:0];
    end
    cor_re_sh = (s_re + cpc_pkg::SUM_W'(cpc_pkg::COR_ROUND)) >>> cpc_pkg::COR_SHIFT;
    cor_im_sh = (s_im + cpc_pkg::SUM_W'(cpc_pkg::COR_ROUND)) >>> cpc_pkg::COR_SHIFT;
    smo_re_sh = (s_re + cpc_pkg::SUM_W'(cpc_pkg::SMOOTH_ROUND)) >>> cpc_pkg::SMOOTH_SHIFT;
    smo_im_sh = (s_im + cpc_pkg::SUM_W'(cpc_pkg::SMOOTH_ROUND)) >>> cpc_pkg::SMOOTH_SHIFT;
  end

  always_comb begin
    mag_max = (mag_a > mag_b) ? mag_a : mag_b;
    sq_rb = sq_r + sq_bit;
    sq_ge = sq_n >= sq_rb;
    sq_r_next = sq_ge ? (sq_r >> 1) + sq_bit : sq_r >> 1;
    div_x = div_sel ? mag_b[cpc_pkg::NORM_W-1:0] : mag_a[cpc_pkg::NORM_W-1:0];
    div_ge = rem >= den;
    quo_next = {quo[cpc_pkg::Q_BITS-2:0], div_ge};
    quo_s = signed'(cpc_pkg::CORR_W'(quo_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      smoothing <= 1'b0;
      div_sel <= 1'b0;
      acc_re <= '0;
      acc_im <= '0;
      phase_re <= cpc_pkg::ONE_Q14;
      phase_im <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            smoothing <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (smoothing) begin
            state <= S_SADD;
          end else if (item.op == cpc_pkg::OP_COR) begin
            state <= S_COR;
          end else begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc_re <= acc_re_next;
          acc_im <= acc_im_next;
          state <= (item.op == cpc_pkg::OP_ACC_END) ? S_NINIT : S_EMIT;
        end
        S_COR: begin
          state <= S_EMIT;
        end
        S_NINIT: begin
          acc_re <= '0;
          acc_im <= '0;
          div_sel <= 1'b0;
          if (acc_re == '0 && acc_im == '0) begin
            smoothing <= 1'b1;
            state <= S_MUL;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (!(|mag_max[cpc_pkg::ACC_W-1:cpc_pkg::NORM_W]) && mag_max[cpc_pkg::NORM_W-1]) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_SQI;
        end
        S_SQI: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_bit[0]) begin
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_last) begin
            if (div_sel) begin
              smoothing <= 1'b1;
              state <= S_MUL;
            end else begin
              div_sel <= 1'b1;
              state <= S_DINIT;
            end
          end
        end
        S_SADD: begin
          phase_re <= sat_corr(smo_re_sh);
          phase_im <= sat_corr(smo_im_sh);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= pop_item;
    end
    if (state == S_MUL) begin
      for (int i = 0; i < 4; i++) begin
        prod[i] <= prod_next[i];
      end
    end
    if (state == S_SUM) begin
      s_re <= s_re_next;
      s_im <= s_im_next;
    end
    if (state == S_ACC) begin
      res_re <= '0;
      res_im <= '0;
      res_upd <= 1'b0;
    end
    if (state == S_COR) begin
      res_re <= sat_sample(cor_re_sh);
      res_im <= sat_sample(cor_im_sh);
      res_upd <= 1'b0;
    end
    if (state == S_SADD) begin
      res_re <= '0;
      res_im <= '0;
      res_upd <= 1'b1;
    end
    if (state == S_NINIT) begin
      mag_a <= cpc_pkg::ACC_W'(acc_re[cpc_pkg::ACC_W-1] ? -acc_re : acc_re);
      mag_b <= cpc_pkg::ACC_W'(acc_im[cpc_pkg::ACC_W-1] ? -acc_im : acc_im);
      neg_re <= acc_re[cpc_pkg::ACC_W-1];
      pos_im <= !acc_im[cpc_pkg::ACC_W-1] && (acc_im != '0);
      est_re <= cpc_pkg::ONE_Q14;
      est_im <= '0;
    end
    if (state == S_NORM) begin
      if (|mag_max[cpc_pkg::ACC_W-1:cpc_pkg::NORM_W]) begin
        mag_a <= mag_a >> 1;
        mag_b <= mag_b >> 1;
      end else if (!mag_max[cpc_pkg::NORM_W-1]) begin
        mag_a <= mag_a << 1;
        mag_b <= mag_b << 1;
      end
    end
    if (state == S_SQ) begin
      sq_a <= mag_a[cpc_pkg::NORM_W-1:0] * mag_a[cpc_pkg::NORM_W-1:0];
      sq_b <= mag_b[cpc_pkg::NORM_W-1:0] * mag_b[cpc_pkg::NORM_W-1:0];
    end
    if (state == S_SQI) begin
      sq_n <= cpc_pkg::SQ_W'(sq_a) + cpc_pkg::SQ_W'(sq_b);
      sq_r <= '0;
      sq_bit <= cpc_pkg::SQ_TOP;
    end
    if (state == S_SQRT) begin
      if (sq_ge) begin
        sq_n <= sq_n - sq_rb;
      end
      sq_r <= sq_r_next;
      sq_bit <= sq_bit >> 2;
      if (sq_bit[0]) begin
        mag <= sq_r_next[cpc_pkg::MAG_W-1:0];
      end
    end
    if (state == S_DINIT) begin
      rem <= cpc_pkg::DIV_W'({div_x, {cpc_pkg::FRAC_W{1'b0}}})
             + cpc_pkg::DIV_W'(mag >> 1);
      den <= {mag, {cpc_pkg::FRAC_W{1'b0}}};
      quo <= '0;
      dcnt <= '0;
    end
    if (state == S_DIV) begin
      if (div_ge) begin
        rem <= rem - den;
      end
      den <= den >> 1;
      quo <= quo_next;
      dcnt <= dcnt + cpc_pkg::DCNT_W'(1);
      if (div_last) begin
        if (div_sel) begin
          est_im <= pos_im ? -quo_s : quo_s;
        end else begin
          est_re <= neg_re ? -quo_s : quo_s;
        end
      end
    end
    if (state == S_EMIT && slot_free) begin
      out_data.out_re <= res_re;
      out_data.out_im <= res_im;
      out_data.corr_re <= phase_re;
      out_data.corr_im <= phase_im;
      out_data.corr_updated <= res_upd;
    end
  end

endmodule

// ===== rtl/correlation_phase_corrector.sv =====
// Top level of the correlation phase corrector: front end, queue, back end and weight register.
// Estimate items add sample times conj(reference) to a 48-bit complex accumulator; the item
// that ends a block normalizes the conjugated sum to unit magnitude, blends it into the stored
// Q2.14 correction with the smoothing weight, and clears the accumulator. Correct items multiply
// the sample by the stored correction. Every item gives exactly one result. The back end works on
// one item at a time; an item that ends a block also runs the normalizing shift, one bit per
// cycle, the 31-step square root and the shared 15-step divider, used once per part, all skipped
// when the sum is zero. The front stage and a four-item queue keep taking items while the back
// end works. The smoothing weight is written over the configuration channel; the user must write
// it only while the block is idle, as the block itself does not enforce this.
module correlation_phase_corrector (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cpc_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cpc_pkg::out_t                out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cpc_pkg::WEIGHT_W-1:0] cfg_data
);

  logic [cpc_pkg::WEIGHT_W-1:0] smoothing_weight;
  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_empty;
  cpc_pkg::item_t               q_in_item;
  cpc_pkg::item_t               q_out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_weight <= cpc_pkg::WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      smoothing_weight <= cfg_data;
    end
  end

  cpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full)
  );

  cpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  cpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .weight    (smoothing_weight),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_update_zero_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.corr_updated) |-> (out_data.out_re == '0 && out_data.out_im == '0))
    else $error("Correction update item carries a nonzero corrected sample.");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("Item pushed into a full queue.");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("Item popped from an empty queue.");
`endif

endmodule

// ===== tb/correlation_phase_corrector_tb.sv =====
// Self-checking testbench for the correlation phase corrector: directed table and random blocks.
module correlation_phase_corrector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [cpc_pkg::SAMPLE_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [cpc_pkg::SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam longint SUM_HI = (64'sd1 <<< 47) - 64'sd1;
  localparam longint SUM_LO = -(64'sd1 <<< 47);
  localparam int DIR_ROWS = 19;
  localparam int PHASE_ITEMS = 260;

  typedef struct packed {
    cpc_pkg::in_t  d;
    logic          typed;
    cpc_pkg::out_t want;
  } row_t;

  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{'{cpc_pkg::ACT_COR, S_MAX, S_MIN, 16'sd0, 16'sd0, 1'b0}, 1'b1,
      '{S_MAX, S_MIN, cpc_pkg::ONE_Q14, 16'sd0, 1'b0}},
    '{'{cpc_pkg::ACT_COR, S_MIN, S_MAX, S_MAX, S_MIN, 1'b1}, 1'b1,
      '{S_MIN, S_MAX, cpc_pkg::ONE_Q14, 16'sd0, 1'b0}},
    '{'{cpc_pkg::ACT_COR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b1,
      '{16'sd0, 16'sd0, cpc_pkg::ONE_Q14, 16'sd0, 1'b0}},
    '{'{cpc_pkg::ACT_ACC, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b1,
      '{16'sd0, 16'sd0, cpc_pkg::ONE_Q14, 16'sd0, 1'b1}},
    '{'{cpc_pkg::ACT_ACC, S_MAX, 16'sd0, S_MAX, 16'sd0, 1'b0}, 1'b1,
      '{16'sd0, 16'sd0, cpc_pkg::ONE_Q14, 16'sd0, 1'b0}},
    '{'{cpc_pkg::ACT_ACC, S_MAX, 16'sd0, S_MAX, 16'sd0, 1'b1}, 1'b1,
      '{16'sd0, 16'sd0, cpc_pkg::ONE_Q14, 16'sd0, 1'b1}},
    '{'{cpc_pkg::ACT_ACC, 16'sd0, S_MAX, S_MAX, 16'sd0, 1'b1}, 1'b0, '0},
    '{'{cpc_pkg::ACT_COR, S_MAX, S_MAX, 16'sd0, 16'sd0, 1'b0}, 1'b0, '0},
    '{'{cpc_pkg::ACT_COR, S_MIN, S_MIN, 16'sd0, 16'sd0, 1'b0}, 1'b0, '0},
    '{'{cpc_pkg::ACT_COR, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b0}, 1'b0, '0},
    '{'{cpc_pkg::ACT_ACC, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0}, 1'b0, '0},
    '{'{cpc_pkg::ACT_ACC, S_MAX, S_MIN, S_MIN, S_MAX, 1'b1}, 1'b0, '0},
    '{'{cpc_pkg::ACT_ACC, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 1'b1}, 1'b0, '0},
    '{'{cpc_pkg::ACT_ACC, -16'sd1, 16'sd0, 16'sd1, 16'sd0, 1'b1}, 1'b0, '0},
    '{'{cpc_pkg::ACT_COR, S_MAX, S_MIN, S_MAX, S_MAX, 1'b0}, 1'b0, '0},
    '{'{cpc_pkg::ACT_COR, -16'sd3, 16'sd5, 16'sd0, 16'sd0, 1'b1}, 1'b0, '0},
    '{'{cpc_pkg::ACT_ACC, S_MIN, 16'sd0, S_MIN, 16'sd0, 1'b0}, 1'b0, '0},
    '{'{cpc_pkg::ACT_COR, 16'sd1000, -16'sd2000, S_MIN, S_MIN, 1'b0}, 1'b0, '0},
    '{'{cpc_pkg::ACT_ACC, 16'sd0, S_MIN, S_MIN, 16'sd0, 1'b1}, 1'b0, '0}
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cpc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cpc_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cpc_pkg::WEIGHT_W-1:0] cfg_data = '0;

  longint corr_sum_re, corr_sum_im;
  int phase_re_q, phase_im_q;
  logic [cpc_pkg::WEIGHT_W-1:0] weight_q;
  cpc_pkg::out_t pending_results[$];
  cpc_pkg::out_t want;
  bit idling;
  bit failed;
  int stall_left;

  correlation_phase_corrector u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("correlation_phase_corrector_tb NOT OK");
    $finish;
  end

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic int blend(longint est, longint old);
    longint w, s;
    w = longint'(weight_q);
    s = w * est + (longint'(cpc_pkg::WEIGHT_ONE) - w) * old;
    return int'(clamp((s + cpc_pkg::SMOOTH_ROUND) >>> cpc_pkg::SMOOTH_SHIFT, -32768, 32767));
  endfunction

  function automatic cpc_pkg::out_t corrector_step(cpc_pkg::in_t d);
    cpc_pkg::out_t r;
    longint sr, si, rr, ri, pre, pim, est_re, est_im;
    longint unsigned a, b, m, n, root, sq_bit;
    r = '0;
    sr = longint'(d.sample_re);
    si = longint'(d.sample_im);
    rr = longint'(d.ref_re);
    ri = longint'(d.ref_im);
    if (d.action == cpc_pkg::ACT_ACC) begin
      corr_sum_re = clamp(corr_sum_re + sr * rr + si * ri, SUM_LO, SUM_HI);
      corr_sum_im = clamp(corr_sum_im + si * rr - sr * ri, SUM_LO, SUM_HI);
      if (d.block_end) begin
        est_re = longint'(cpc_pkg::ONE_Q14);
        est_im = 0;
        a = corr_sum_re < 0 ? -corr_sum_re : corr_sum_re;
        b = corr_sum_im < 0 ? -corr_sum_im : corr_sum_im;
        m = a > b ? a : b;
        if (m != 0) begin
          while (m >= (64'd1 << 30)) begin
            a >>= 1;
            b >>= 1;
            m >>= 1;
          end
          while (m < (64'd1 << 29)) begin
            a <<= 1;
            b <<= 1;
            m <<= 1;
          end
          n = a * a + b * b;
          root = 0;
          sq_bit = 64'd1 << 62;
          while (sq_bit > n) sq_bit >>= 2;
          while (sq_bit != 0) begin
            if (n >= root + sq_bit) begin
              n -= root + sq_bit;
              root = (root >> 1) + sq_bit;
            end else begin
              root >>= 1;
            end
            sq_bit >>= 2;
          end
          est_re = longint'((a * 16384 + root / 2) / root);
          est_im = longint'((b * 16384 + root / 2) / root);
          if (corr_sum_re < 0) est_re = -est_re;
          if (corr_sum_im > 0) est_im = -est_im;
        end
        phase_re_q = blend(est_re, phase_re_q);
        phase_im_q = blend(est_im, phase_im_q);
        corr_sum_re = 0;
        corr_sum_im = 0;
        r.corr_updated = 1'b1;
      end
    end else begin
      pre = sr * phase_re_q - si * phase_im_q;
      pim = sr * phase_im_q + si * phase_re_q;
      r.out_re = cpc_pkg::SAMPLE_W'(clamp((pre + cpc_pkg::COR_ROUND) >>> cpc_pkg::COR_SHIFT,
                                          -32768, 32767));
      r.out_im = cpc_pkg::SAMPLE_W'(clamp((pim + cpc_pkg::COR_ROUND) >>> cpc_pkg::COR_SHIFT,
                                          -32768, 32767));
    end
    r.corr_re = phase_re_q[cpc_pkg::CORR_W-1:0];
    r.corr_im = phase_im_q[cpc_pkg::CORR_W-1:0];
    return r;
  endfunction

  function automatic logic signed [cpc_pkg::SAMPLE_W-1:0] pick_value(int kind);
    case (kind)
      0: return cpc_pkg::SAMPLE_W'($urandom);
      1: return cpc_pkg::SAMPLE_W'($urandom_range(0, 16) - 8);
      2: begin
        case ($urandom_range(0, 2))
          0: return S_MIN;
          1: return S_MAX;
          default: return cpc_pkg::SAMPLE_W'($urandom);
        endcase
      end
      default: return '0;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [15:0] want_v,
                                      logic signed [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      failed = 1'b1;
    end
  endfunction

  task automatic send_item(input cpc_pkg::in_t d, input logic typed,
                           input cpc_pkg::out_t typed_res);
    cpc_pkg::out_t res;
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = corrector_step(d);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic write_weight(input logic [cpc_pkg::WEIGHT_W-1:0] w);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    weight_q = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %p", $time, out_data);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("out_re", want.out_re, out_data.out_re);
        check_field("out_im", want.out_im, out_data.out_im);
        check_field("corr_re", want.corr_re, out_data.corr_re);
        check_field("corr_im", want.corr_im, out_data.corr_im);
        check_field("corr_updated", {15'd0, want.corr_updated}, {15'd0, out_data.corr_updated});
      end
    end
  end

  initial begin : stimulus
    cpc_pkg::in_t d;
    int i, phase, count, len, kind, roll;
    logic [cpc_pkg::WEIGHT_W-1:0] weights [6];
    corr_sum_re = 0;
    corr_sum_im = 0;
    phase_re_q = cpc_pkg::ONE_Q14;
    phase_im_q = 0;
    weight_q = cpc_pkg::WEIGHT_RESET;
    idling = 1'b1;
    failed = 1'b0;
    stall_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) send_item(DIRECTED[i].d, DIRECTED[i].typed, DIRECTED[i].want);

    weights = '{16'hffff, 16'h0000, 16'h0001, 16'($urandom), cpc_pkg::WEIGHT_RESET,
                16'($urandom)};
    for (phase = 0; phase < 6; phase++) begin
      write_weight(weights[phase]);
      count = 0;
      while (count < PHASE_ITEMS) begin
        idling = (phase != 5) && ($urandom_range(0, 3) != 0);
        roll = $urandom_range(0, 9);
        kind = roll < 6 ? 0 : (roll < 8 ? 1 : (roll == 8 ? 2 : 3));
        len = $urandom_range(1, 24);
        for (i = 0; i < len; i++) begin
          d.sample_re = pick_value(kind);
          d.sample_im = pick_value(kind);
          d.ref_re = pick_value(kind);
          d.ref_im = pick_value(kind);
          roll = $urandom_range(0, 99);
          if (roll < 15) begin
            d.action = cpc_pkg::ACT_COR;
            d.block_end = 1'($urandom_range(0, 1));
          end else if (roll < 20) begin
            d.action = cpc_pkg::ACT_ACC;
            d.block_end = 1'b1;
          end else begin
            d.action = cpc_pkg::ACT_ACC;
            d.block_end = (i == len - 1);
          end
          send_item(d, 1'b0, '0);
          count++;
        end
      end
    end

    in_valid <= 1'b0;
    idling = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (!failed) begin
      $display("correlation_phase_corrector_tb OK");
    end else begin
      $display("correlation_phase_corrector_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cpc_pkg.sv
rtl/cpc_front.sv
rtl/cpc_queue.sv
rtl/cpc_back.sv
rtl/correlation_phase_corrector.sv
tb/correlation_phase_corrector_tb.sv
